### hdl/mbp_pkg.sv
// shared types and constants for the msb-first bit packer
package mbp_pkg;

  localparam int MAX_FIELD_BITS = 32;
  localparam int VALUE_BITS     = 32;
  localparam int BYTE_BITS      = 8;
  localparam int QUEUE_DEPTH    = 2;

  // effective field length limit, never above the width of value
  localparam logic [5:0] FIELD_LIMIT =
    6'((MAX_FIELD_BITS < VALUE_BITS) ? MAX_FIELD_BITS : VALUE_BITS);

  typedef struct packed {
    logic [31:0] value;
    logic [5:0]  num_bits;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } out_t;

  // up to four finished bytes of one item, first byte in the top bits
  typedef struct packed {
    logic [31:0] bytes;
    logic [2:0]  cnt;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### hdl/mbp_front.sv
// front end: accepts fields, merges them with the partial byte, emits byte jobs
module mbp_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  mbp_pkg::in_t   in_data,
  input  logic           q_full,
  output logic           in_stall,
  output logic           push,
  output mbp_pkg::job_t  job
);

  logic [7:0]  partial_r, partial_nxt;
  logic [2:0]  held_r, held_nxt;
  logic [5:0]  n;
  logic [31:0] vmasked;
  logic [5:0]  sh;
  logic [39:0] stream;
  logic [5:0]  total;
  logic        accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    n = (in_data.num_bits > mbp_pkg::FIELD_LIMIT) ? mbp_pkg::FIELD_LIMIT
                                                   : in_data.num_bits;
    vmasked = in_data.value & (32'hFFFF_FFFF >> (6'd32 - n));
    // field lands right after the held bits
    sh      = 6'd40 - {3'b000, held_r} - n;
    stream  = {partial_r, 32'h0} | ({8'h0, vmasked} << sh);
    total   = {3'b000, held_r} + n;

    job         = '0;
    partial_nxt = partial_r;
    held_nxt    = held_r;

    if (in_data.num_bits == 6'd0) begin
      // flush
      if (held_r != 3'd0) begin
        job.bytes = {partial_r, 24'h0};
        job.cnt   = 3'd1;
      end
      partial_nxt = 8'h00;
      held_nxt    = 3'd0;
    end else begin
      job.bytes = stream[39:8];
      job.cnt   = total[5:3];
      held_nxt  = total[2:0];
      case (total[5:3])
        3'd0:    partial_nxt = stream[39:32];
        3'd1:    partial_nxt = stream[31:24];
        3'd2:    partial_nxt = stream[23:16];
        3'd3:    partial_nxt = stream[15:8];
        3'd4:    partial_nxt = stream[7:0];
        default: partial_nxt = 8'h00;
      endcase
    end
  end

  assign push = accept && (job.cnt != 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= 8'h00;
      held_r    <= 3'd0;
    end else if (accept) begin
      partial_r <= partial_nxt;
      held_r    <= held_nxt;
    end
  end

endmodule

### hdl/mbp_queue.sv
// two-entry job queue between front and back
module mbp_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  mbp_pkg::job_t    wr_job,
  input  logic             pop,
  output mbp_pkg::job_t    rd_job,
  output mbp_pkg::q_stat_t stat
);

  mbp_pkg::job_t mem_r [mbp_pkg::QUEUE_DEPTH];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    fill_r, fill_nxt;

  assign rd_job     = mem_r[rd_ptr_r];
  assign stat.full  = (fill_r == 2'(mbp_pkg::QUEUE_DEPTH));
  assign stat.empty = (fill_r == 2'd0);

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

### hdl/mbp_back.sv
// back end: walks each job byte by byte into the output register
module mbp_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  mbp_pkg::job_t head,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output mbp_pkg::out_t out_data
);

  logic          out_valid_r, out_valid_nxt;
  mbp_pkg::out_t out_data_r, out_data_nxt;
  logic [1:0]    idx_r, idx_nxt;
  logic          load;
  logic          last;
  logic [7:0]    cur_byte;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    case (idx_r)
      2'd0:    cur_byte = head.bytes[31:24];
      2'd1:    cur_byte = head.bytes[23:16];
      2'd2:    cur_byte = head.bytes[15:8];
      2'd3:    cur_byte = head.bytes[7:0];
      default: cur_byte = 8'h00;
    endcase
    last = (({1'b0, idx_r} + 3'd1) == head.cnt);
    load = !q_empty && (!out_valid_r || !out_stall);
    pop  = load && last;

    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    idx_nxt       = idx_r;
    if (load) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.out_byte  = cur_byte;
      out_data_nxt.last_byte = last;
      idx_nxt                = last ? 2'd0 : idx_r + 2'd1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

endmodule

### hdl/msb_first_bit_packer.sv
// msb-first bit packer top level: appends fields of 1 to 32 bits to a byte
// stream, most significant bit first, and emits each finished byte as one
// beat; a field count of zero flushes the partial byte with zero padding.
// A new field is taken every cycle while the two-entry job queue has room;
// each field yields zero to four bytes and the byte-wide output drains one
// byte per cycle while out_stall is low, so sustained field throughput falls
// as the number of bytes that each field completes rises.
// With nothing queued ahead and no output stall, the first byte of a field
// is written into the job queue and then registered in the output register.
module msb_first_bit_packer (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  mbp_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output mbp_pkg::out_t out_data
);

  logic             push;
  logic             pop;
  mbp_pkg::job_t    wr_job;
  mbp_pkg::job_t    head;
  mbp_pkg::q_stat_t q_stat;

  mbp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .q_full   (q_stat.full),
    .in_stall (in_stall),
    .push     (push),
    .job      (wr_job)
  );

  mbp_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .rd_job (head),
    .stat   (q_stat)
  );

  mbp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_stat.empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("job pushed into full queue");

  a_job_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (wr_job.cnt != 3'd0 && wr_job.cnt <= 3'd4))
    else $error("job byte count out of range");

  a_pop_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && q_stat.empty))
    else $error("output or queue busy after reset");
`endif

endmodule

### test/msb_first_bit_packer_tb.sv
// testbench for the msb-first bit packer: directed and random fields, bit-accurate predictor
module msb_first_bit_packer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  mbp_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  mbp_pkg::out_t out_data;

  msb_first_bit_packer dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  // predictor state: bits held so far (left justified) and open positions
  logic [7:0] pend_byte = 8'd0;
  logic [3:0] open_bits = 4'd8;
  mbp_pkg::out_t expected_bytes[$];

  int mismatch_count = 0;
  int fields_sent = 0;
  int flushes_sent = 0;
  int overlong_sent = 0;
  int bytes_checked = 0;
  bit gaps_on = 1'b1;

  initial begin
    forever #5 clk = ~clk;
  end

  // works out the bytes one field completes and advances the predictor state
  function automatic void pack_field(input mbp_pkg::in_t beat);
    logic [5:0] nbits;
    logic [63:0] acc;
    int held;
    int total;
    int nbytes;
    mbp_pkg::out_t res;
    nbits = beat.num_bits;
    if (nbits == 6'd0) begin
      if (open_bits != 4'd8) begin
        res.out_byte = pend_byte;
        res.last_byte = 1'b1;
        expected_bytes.push_back(res);
      end
      pend_byte = 8'd0;
      open_bits = 4'd8;
      return;
    end
    if (nbits > mbp_pkg::FIELD_LIMIT) nbits = mbp_pkg::FIELD_LIMIT;
    held = mbp_pkg::BYTE_BITS - int'(open_bits);
    acc = 64'(pend_byte) >> open_bits;
    acc = (acc << nbits) | (64'(beat.value) & ((64'd1 << nbits) - 64'd1));
    total = held + int'(nbits);
    nbytes = total / mbp_pkg::BYTE_BITS;
    for (int i = 0; i < nbytes; i++) begin
      res.out_byte = 8'(acc >> (total - mbp_pkg::BYTE_BITS * (i + 1)));
      res.last_byte = (i == nbytes - 1);
      expected_bytes.push_back(res);
    end
    total = total - mbp_pkg::BYTE_BITS * nbytes;
    pend_byte = 8'((acc & ((64'd1 << total) - 64'd1)) << (mbp_pkg::BYTE_BITS - total));
    open_bits = 4'(mbp_pkg::BYTE_BITS - total);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // sends one field beat and holds it until taken; called at a rising edge
  task automatic push_field(input logic [31:0] v, input logic [5:0] n);
    mbp_pkg::in_t beat;
    int gap;
    logic taken;
    beat.value = v;
    beat.num_bits = n;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    pack_field(beat);
    fields_sent++;
    if (n == 6'd0) flushes_sent++;
    if (n > mbp_pkg::FIELD_LIMIT) overlong_sent++;
  endtask

  // output stall pattern: free-running, light, and heavy with long holds
  int stall_mode = 0;
  int mode_left = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      mode_left <= $urandom_range(20, 120);
    end else begin
      mode_left <= mode_left - 1;
    end
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: begin
          if ($urandom_range(0, 19) == 0) begin
            hold_left <= $urandom_range(8, 25);
            out_stall <= 1'b1;
          end else begin
            out_stall <= ($urandom_range(0, 1) == 0);
          end
        end
      endcase
    end
  end

  // sampled at the falling edge, so this is the beat the next rising edge takes
  always @(negedge clk) begin
    mbp_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected beat: out_byte %02h last_byte %0b", out_data.out_byte,
               out_data.last_byte);
        mismatch_count++;
      end else begin
        want = expected_bytes.pop_front();
        bytes_checked++;
        if (out_data.out_byte !== want.out_byte) begin
          $error("out_byte: expected %02h, got %02h", want.out_byte, out_data.out_byte);
          mismatch_count++;
        end
        if (out_data.last_byte !== want.last_byte) begin
          $error("last_byte: expected %0b, got %0b", want.last_byte, out_data.last_byte);
          mismatch_count++;
        end
      end
    end
  end

  task automatic test_basic_fields();
    push_field(32'hFFFF_FFFF, 6'd0);   // flush with nothing held
    push_field(32'h0000_00A5, 6'd8);
    push_field(32'h0000_0001, 6'd1);
    push_field(32'h0000_0000, 6'd0);   // flush pads low bits with zero
    push_field(32'h0000_0005, 6'd3);
    push_field(32'h0000_006B, 6'd7);   // straddles a byte boundary
    push_field(32'hFFFF_FFF0, 6'd4);   // upper value bits must be dropped
    push_field(32'h0000_0000, 6'd0);
  endtask

  task automatic test_wide_fields();
    push_field(32'hFFFF_FFFF, 6'd32);
    push_field(32'h0000_0000, 6'd32);
    push_field(32'h0000_0006, 6'd3);
    push_field(32'h1234_5678, 6'd32);  // four bytes with bits left over
    push_field(32'h7FFF_FFFF, 6'd31);
    push_field(32'h0000_0001, 6'd1);
    push_field(32'h0000_0000, 6'd0);
  endtask

  task automatic test_count_saturation();
    push_field(32'hDEAD_BEEF, 6'd33);
    push_field(32'h0000_0002, 6'd2);
    push_field(32'hA5A5_5A5A, 6'd63);
    push_field(32'h8000_0001, 6'd48);
    push_field(32'h0000_0000, 6'd0);
    push_field(32'h0000_0000, 6'd0);
  endtask

  function automatic logic [5:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 6'd0;
    if (r < 14) return 6'($urandom_range(33, 63));
    if (r < 28) return 6'd32;
    return 6'($urandom_range(1, 31));
  endfunction

  task automatic test_random_fields(input int count);
    for (int i = 0; i < count; i++) push_field($urandom, pick_count());
  endtask

  task automatic test_back_to_back(input int count);
    gaps_on = 1'b0;
    for (int i = 0; i < count; i++) push_field($urandom, pick_count());
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_basic_fields();
    test_wide_fields();
    test_count_saturation();
    test_random_fields(80);
    test_back_to_back(30);
    test_random_fields(20);
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    $display("covered %0d fields, %0d of them flushes and %0d over-long counts",
             fields_sent, flushes_sent, overlong_sent);
    $display("checked %0d stream bytes under random input gaps and output stalls",
             bytes_checked);
    if (mismatch_count == 0 && expected_bytes.size() == 0) begin
      $display("msb_first_bit_packer_tb: done, clean");
    end else begin
      $display("msb_first_bit_packer_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $error("timeout with %0d bytes still expected", expected_bytes.size());
    $display("msb_first_bit_packer_tb: done, errors");
    $finish;
  end

endmodule
